>>> rtl/core/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg - shared types and constants for the control time mapper
// Widths, repeat mode and register codes, pipeline entry types and the
// one-bit restoring divide step used by the back end.
// ----------------------------------------------------------------------------
package atc_pkg;

  localparam int TIME_BITS  = 48;
  localparam int FRAC_BITS  = 16;
  localparam int RATE_BITS  = 32;
  localparam int LO_BITS    = TIME_BITS / 2;
  localparam int HI_BITS    = TIME_BITS - LO_BITS;
  localparam int PROD_BITS  = TIME_BITS + RATE_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = TIME_BITS;

  localparam logic [1:0] MODE_CLAMP = 2'd0;
  localparam logic [1:0] MODE_WRAP  = 2'd1;
  localparam logic [1:0] MODE_CYCLE = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_MODE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_TIME     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TIME     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATE_SCALE   = 3'd4;

  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(65536);

  typedef logic signed [TIME_BITS-1:0] time_t;
  typedef logic        [TIME_BITS-1:0] utime_t;
  typedef logic signed [RATE_BITS-1:0] rate_t;

  // queue entry between front and back
  typedef struct packed {
    logic  sat;
    time_t ctl;
  } qent_t;

  // one divider stage; on bypass dvd carries the final result untouched
  typedef struct packed {
    logic   byp;
    logic   neg;
    logic   cyc;
    logic   sat;
    logic   q;
    utime_t rem;
    utime_t dvd;
  } dstg_t;

  function automatic dstg_t div_step(dstg_t s, utime_t rng);
    dstg_t           o;
    logic [TIME_BITS:0] tmp;
    logic            ge;
    o   = s;
    tmp = {s.rem, s.dvd[TIME_BITS-1]};
    ge  = tmp >= {1'b0, rng};
    if (!s.byp) begin
      o.q   = ge;
      o.rem = ge ? TIME_BITS'(tmp - {1'b0, rng}) : tmp[TIME_BITS-1:0];
      o.dvd = {s.dvd[TIME_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/core/atc_in_if.sv
// ----------------------------------------------------------------------------
// atc_in_if - application time request channel
// Valid/ready channel carrying one application time per request.
// ----------------------------------------------------------------------------
interface atc_in_if;
  logic           valid;
  logic           ready;
  atc_pkg::time_t app_time;

  modport source (output valid, output app_time, input ready);
  modport sink   (input valid, input app_time, output ready);
endinterface

>>> rtl/core/atc_out_if.sv
// ----------------------------------------------------------------------------
// atc_out_if - control time result channel
// Valid/ready channel carrying the mapped control time and saturation flag.
// ----------------------------------------------------------------------------
interface atc_out_if;
  logic           valid;
  logic           ready;
  atc_pkg::time_t control_time;
  logic           saturated;

  modport source (output valid, output control_time, output saturated, input ready);
  modport sink   (input valid, input control_time, input saturated, output ready);
endinterface

>>> rtl/core/atc_front.sv
// ----------------------------------------------------------------------------
// atc_front - scale, phase and saturate
// Three stages: split multiply, recombine with floor shift and saturation,
// phase add with saturation. Stalls as a whole when the last stage holds an entry and the queue is full.
// ----------------------------------------------------------------------------
module atc_front (
  input  logic              clk,
  input  logic              rst,
  atc_in_if.sink            in_ch,
  input  atc_pkg::rate_t    rate_scale,
  input  atc_pkg::time_t    phase_offset,
  input  logic              q_full,
  output logic              push,
  output atc_pkg::qent_t    ent
);

  localparam int PL_BITS = atc_pkg::LO_BITS + 1 + atc_pkg::RATE_BITS;
  localparam int PH_BITS = atc_pkg::HI_BITS + atc_pkg::RATE_BITS;
  localparam int PW      = atc_pkg::PROD_BITS;
  localparam int TB      = atc_pkg::TIME_BITS;

  logic                      en;
  logic                      v0, v1, v2;
  logic signed [PL_BITS-1:0] pl;
  logic signed [PH_BITS-1:0] ph;
  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      shifted;
  logic                      fits;
  atc_pkg::time_t            sc, sc_next;
  logic                      sat1;
  logic signed [TB:0]        sum;
  atc_pkg::time_t            ctl, ctl_next;
  logic                      sat2, sat2_next;

  assign en          = !v2 || !q_full;
  assign in_ch.ready = en;
  assign push        = v2 && en;
  assign ent.ctl     = ctl;
  assign ent.sat     = sat2;

  // recombine partial products and floor the fraction away
  assign prod    = (PW'(ph) <<< atc_pkg::LO_BITS) + PW'(pl);
  assign shifted = prod >>> atc_pkg::FRAC_BITS;
  assign fits    = (&shifted[PW-1:TB-1]) || !(|shifted[PW-1:TB-1]);
  always_comb begin
    if (fits) begin
      sc_next = shifted[TB-1:0];
    end else begin
      sc_next = shifted[PW-1] ? {1'b1, {(TB-1){1'b0}}} : {1'b0, {(TB-1){1'b1}}};
    end
  end

  assign sum = {sc[TB-1], sc} + {phase_offset[TB-1], phase_offset};
  always_comb begin
    sat2_next = sat1;
    ctl_next  = sum[TB-1:0];
    if (sum[TB] != sum[TB-1]) begin
      sat2_next = 1'b1;
      ctl_next  = sum[TB] ? {1'b1, {(TB-1){1'b0}}} : {1'b0, {(TB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl   <= $signed({1'b0, in_ch.app_time[atc_pkg::LO_BITS-1:0]}) * rate_scale;
      ph   <= $signed(in_ch.app_time[TB-1:atc_pkg::LO_BITS]) * rate_scale;
      sc   <= sc_next;
      sat1 <= !fits;
      ctl  <= ctl_next;
      sat2 <= sat2_next;
    end
  end

endmodule

>>> rtl/core/atc_queue.sv
// ----------------------------------------------------------------------------
// atc_queue - short request queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module atc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  atc_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output atc_pkg::qent_t head
);

  localparam int PB = atc_pkg::QPTR_BITS;

  atc_pkg::qent_t mem [atc_pkg::QUEUE_DEPTH];
  logic [PB-1:0]  wr_ptr, rd_ptr;
  logic [PB:0]    count;

  assign full    = count == (PB+1)'(atc_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_ent;
  end

endmodule

>>> rtl/core/atc_back.sv
// ----------------------------------------------------------------------------
// atc_back - interval mapping
// Classifies each control time (clamp, divide, empty interval), runs a
// one-bit-per-stage restoring divider for wrap and cycle, then folds the
// remainder back into the interval. Output register is the last stage.
// ----------------------------------------------------------------------------
module atc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     repeat_mode,
  input  atc_pkg::time_t min_time,
  input  atc_pkg::time_t max_time,
  input  logic           q_valid,
  input  atc_pkg::qent_t head,
  output logic           pop,
  atc_out_if.source      out_ch
);

  localparam int TB = atc_pkg::TIME_BITS;

  logic              en;
  logic [TB:0]       vld;
  atc_pkg::dstg_t    stg [TB+1];
  atc_pkg::dstg_t    entry;
  atc_pkg::utime_t   rng;
  logic signed [TB:0] diff;
  logic              post_v, out_v;
  logic              p_byp, p_odd, p_cyc, p_sat;
  atc_pkg::utime_t   p_val;
  logic              nz;
  atc_pkg::time_t    res;
  logic              out_sat;

  assign en           = !out_v || out_ch.ready;
  assign pop          = q_valid && en;
  assign out_ch.valid = out_v;
  assign out_ch.control_time = res;
  assign out_ch.saturated    = out_sat;

  assign diff = {head.ctl[TB-1], head.ctl} - {min_time[TB-1], min_time};

  always_comb begin
    entry     = '0;
    entry.sat = head.sat;
    entry.cyc = repeat_mode != atc_pkg::MODE_WRAP;
    entry.byp = 1'b1;
    if (repeat_mode == atc_pkg::MODE_CLAMP) begin
      priority if (head.ctl < min_time) begin
        entry.dvd = min_time;
      end else if (head.ctl > max_time) begin
        entry.dvd = max_time;
      end else begin
        entry.dvd = head.ctl;
      end
    end else if (min_time < max_time) begin
      entry.byp = 1'b0;
      entry.neg = diff[TB];
      entry.dvd = diff[TB] ? TB'(min_time - head.ctl) : diff[TB-1:0];
    end else begin
      entry.dvd = min_time;
    end
  end

  always_ff @(posedge clk) begin
    rng <= max_time - min_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      post_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (en) begin
      vld    <= {vld[TB-1:0], q_valid};
      post_v <= vld[TB];
      out_v  <= post_v;
    end
  end

  assign nz = |stg[TB].rem;

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= entry;
      for (int k = 0; k < TB; k++) begin
        stg[k+1] <= atc_pkg::div_step(stg[k], rng);
      end
      // floor correction for a negative offset
      p_byp <= stg[TB].byp;
      p_cyc <= stg[TB].cyc;
      p_sat <= stg[TB].sat;
      p_odd <= stg[TB].q ^ (stg[TB].neg && nz);
      if (stg[TB].byp) begin
        p_val <= stg[TB].dvd;
      end else if (stg[TB].neg && nz) begin
        p_val <= rng - stg[TB].rem;
      end else begin
        p_val <= stg[TB].rem;
      end
      out_sat <= p_sat;
      if (p_byp) begin
        res <= p_val;
      end else if (p_cyc && p_odd) begin
        res <= max_time - p_val;
      end else begin
        res <= min_time + p_val;
      end
    end
  end

endmodule

>>> rtl/core/animation_time_clamp_wrap_cycle.sv
// ----------------------------------------------------------------------------
// animation_time_clamp_wrap_cycle - animation control time mapper
// Scales an application time, adds a phase, then clamps, wraps or cycles
// it over [min_time, max_time].
//
//   channel  dir  payload                        handshake
//   in_ch    in   app_time                       valid/ready
//   out_ch   out  control_time, saturated        valid/ready
//   cfg      in   cfg_idx, cfg_data              cfg_we, no back-pressure
//
// One request per cycle sustained while out_ch is ready. A request passes, in
// order, three front stages, the queue, classify, TIME_BITS divider stages
// (one quotient bit each), fold and output register.
// Front and back stall independently; the four-entry queue absorbs the gap.
// Synchronous reset clears control state; configuration returns to defaults.
// ----------------------------------------------------------------------------
module animation_time_clamp_wrap_cycle (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [atc_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [atc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  atc_in_if.sink                               in_ch,
  atc_out_if.source                            out_ch
);

  logic [1:0]      repeat_mode;
  atc_pkg::time_t  min_time, max_time, phase_offset;
  atc_pkg::rate_t  rate_scale;
  logic            q_push, q_full, q_pop, q_valid;
  atc_pkg::qent_t  q_in, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_mode  <= atc_pkg::MODE_CLAMP;
      min_time     <= '0;
      max_time     <= '0;
      phase_offset <= '0;
      rate_scale   <= atc_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        atc_pkg::REG_REPEAT_MODE:  repeat_mode  <= cfg_data[1:0];
        atc_pkg::REG_MIN_TIME:     min_time     <= cfg_data[atc_pkg::TIME_BITS-1:0];
        atc_pkg::REG_MAX_TIME:     max_time     <= cfg_data[atc_pkg::TIME_BITS-1:0];
        atc_pkg::REG_PHASE_OFFSET: phase_offset <= cfg_data[atc_pkg::TIME_BITS-1:0];
        atc_pkg::REG_RATE_SCALE:   rate_scale   <= cfg_data[atc_pkg::RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  atc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .rate_scale   (rate_scale),
    .phase_offset (phase_offset),
    .q_full       (q_full),
    .push         (q_push),
    .ent          (q_in)
  );

  atc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .head     (q_head)
  );

  atc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .repeat_mode (repeat_mode),
    .min_time    (min_time),
    .max_time    (max_time),
    .q_valid     (q_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_ch      (out_ch)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");
  a_pop_data: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue pop while empty");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - control time mapper regression
// Drives application times through the mapper under several register
// settings, predicts each control time and saturation flag in the bench
// and compares every result in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import atc_pkg::*;

  localparam int LATENCY   = TIME_BITS + 7;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic  sat;
    time_t ctl;
  } ctl_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  atc_in_if  in_ch ();
  atc_out_if out_ch ();

  animation_time_clamp_wrap_cycle i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // bench copy of the registers
  logic [1:0] mode_r;
  time_t      min_r, max_r, phase_r;
  rate_t      rate_r;

  time_t    pending_times[$];
  ctl_res_t expected_ctl[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       cycle_cnt = 0;
  bit       calm = 1'b0;
  bit       hold_send = 1'b0;

  localparam logic signed [127:0] TMAX_W = (128'sd1 <<< (TIME_BITS - 1)) - 1;
  localparam logic signed [127:0] TMIN_W = -(128'sd1 <<< (TIME_BITS - 1));

  function automatic ctl_res_t map_time(time_t t);
    logic signed [127:0] p, c, mn, mx, rng, d, q, r;
    ctl_res_t res;
    res.sat = 1'b0;
    p = (128'(signed'(t)) * 128'(signed'(rate_r))) >>> FRAC_BITS;
    if (p > TMAX_W) begin p = TMAX_W; res.sat = 1'b1; end
    if (p < TMIN_W) begin p = TMIN_W; res.sat = 1'b1; end
    c = p + 128'(signed'(phase_r));
    if (c > TMAX_W) begin c = TMAX_W; res.sat = 1'b1; end
    if (c < TMIN_W) begin c = TMIN_W; res.sat = 1'b1; end
    mn = 128'(signed'(min_r));
    mx = 128'(signed'(max_r));
    if (mode_r == MODE_CLAMP) begin
      if (c < mn) res.ctl = min_r;
      else if (c > mx) res.ctl = max_r;
      else res.ctl = c[TIME_BITS-1:0];
    end else if (mx > mn) begin
      rng = mx - mn;
      d = c - mn;
      q = d / rng;
      r = d % rng;
      // floor the quotient for negative offsets
      if (r < 0) begin r = r + rng; q = q - 1; end
      if (mode_r != MODE_WRAP && q[0]) res.ctl = TIME_BITS'(mx - r);
      else res.ctl = TIME_BITS'(mn + r);
    end else begin
      res.ctl = min_r;
    end
    return res;
  endfunction

  // driver: one request per accepted handshake
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_ctl.push_back(map_time(in_ch.app_time));
      if (pending_times.size() > 0 && !hold_send && (calm || $urandom_range(99) >= 7)) begin
        in_ch.valid    <= 1'b1;
        in_ch.app_time <= pending_times.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || $urandom_range(99) >= 7;
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_ctl.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %0d", out_ch.control_time);
        end else begin
          ctl_res_t e;
          e = expected_ctl.pop_front();
          if (e.ctl !== out_ch.control_time || e.sat !== out_ch.saturated) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected ctl %0d sat %0b, got ctl %0d sat %0b",
                       e.ctl, e.sat, out_ch.control_time, out_ch.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("animation_time_clamp_wrap_cycle regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_times.size() > 0 || in_ch.valid || expected_ctl.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_REPEAT_MODE:  mode_r  = val[1:0];
      REG_MIN_TIME:     min_r   = val;
      REG_MAX_TIME:     max_r   = val;
      REG_PHASE_OFFSET: phase_r = val;
      REG_RATE_SCALE:   rate_r  = val[RATE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [1:0] m, time_t mn, time_t mx, time_t ph, rate_t rt);
    wait_drained();
    write_reg(REG_REPEAT_MODE, 48'(m));
    write_reg(REG_MIN_TIME, mn);
    write_reg(REG_MAX_TIME, mx);
    write_reg(REG_PHASE_OFFSET, ph);
    write_reg(REG_RATE_SCALE, 48'(signed'(rt)));
    cfg_we <= 1'b0;
  endtask

  function automatic time_t rand_time();
    case ($urandom_range(5))
      0: return time_t'({$urandom, $urandom});
      1: return time_t'($signed($urandom_range(2000)) - 1000);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0, $urandom};
      3: return $urandom_range(1) ? {1'b0, {47{1'b1}}} : {1'b1, 47'b0};
      default: return time_t'($signed({$urandom_range(255), 16'h0}) - 32'sd8388608)
                      + time_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic rate_t rand_rate();
    case ($urandom_range(3))
      0: return rate_t'($urandom);
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return rate_t'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic time_t small_time();
    return time_t'($signed($urandom_range(2000000)) - 1000000);
  endfunction

  initial begin
    time_t mn, mx;
    mode_r = MODE_CLAMP; min_r = '0; max_r = '0; phase_r = '0; rate_r = RATE_RESET;
    in_ch.valid = 1'b0; in_ch.app_time = '0; out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: unit rate, extremes, each mode, empty and inverted interval
    for (int m = 0; m < 3; m++) begin
      set_all(m[1:0], -48'sd100000, 48'sd300000, 48'sd5, 32'sd65536);
      pending_times.push_back({1'b0, {47{1'b1}}});
      pending_times.push_back({1'b1, 47'b0});
      pending_times.push_back(-48'sd100000);
      pending_times.push_back(48'sd300000);
      pending_times.push_back(48'sd700001);
      pending_times.push_back(-48'sd800000);
      pending_times.push_back('0);
    end
    set_all(MODE_CYCLE, 48'sd50, 48'sd50, 48'sd0, 32'sh7fffffff);
    pending_times.push_back({1'b0, {47{1'b1}}});
    pending_times.push_back(-48'sd3);
    set_all(MODE_CLAMP, 48'sd50, -48'sd50, {1'b0, {47{1'b1}}}, 32'sh80000000);
    pending_times.push_back(48'sd1);
    pending_times.push_back(-48'sd1);
    set_all(2'd3, {1'b1, 47'b0}, {1'b0, {47{1'b1}}}, {1'b1, 47'b0}, -32'sd1);
    pending_times.push_back(48'sd12345);
    pending_times.push_back({1'b1, 47'b0});

    // random phases, each with its own register setting
    for (int ph = 0; ph < 30; ph++) begin
      if ($urandom_range(3) == 0) begin mn = rand_time(); mx = rand_time(); end
      else begin mn = small_time(); mx = mn + time_t'($urandom_range(3000000)); end
      set_all(2'($urandom_range(3)), mn, mx,
              $urandom_range(2) == 0 ? rand_time() : small_time(), rand_rate());
      calm = (ph == 10);
      for (int k = 0; k < 60; k++)
        pending_times.push_back($urandom_range(2) == 0 ? rand_time() : small_time());
      if (ph == 5) begin
        // hold off until the pipeline has emptied
        while (pending_times.size() > 30) @(posedge clk);
        hold_send = 1'b1;
        while (in_ch.valid || expected_ctl.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
    end
    wait_drained();
    calm = 1'b0;

    $display("covered %0d results over clamp, wrap, cycle and unused mode settings",
             results_seen);
    $display("including saturated products, empty and inverted intervals");
    if (mismatches == 0) $display("animation_time_clamp_wrap_cycle regression: pass");
    else $display("animation_time_clamp_wrap_cycle regression: fail");
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/atc_pkg.sv
rtl/core/atc_in_if.sv
rtl/core/atc_out_if.sv
rtl/core/atc_front.sv
rtl/core/atc_queue.sv
rtl/core/atc_back.sv
rtl/core/animation_time_clamp_wrap_cycle.sv
bench/tb_top.sv
